[hdl/edns_of_pkg.sv]
// Package for the EDNS option finder: phase encoding, status codes and
// field widths shared by the channel interfaces and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edns_of_pkg;

    // Parse position inside the OPT record
    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_CODE_HI,
        PH_CODE_LO,
        PH_OLEN_HI,
        PH_OLEN_LO,
        PH_SKIP
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_FOUND     = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_INVALID   = 2'd2;

    localparam int unsigned CNT_W = 17;

    // Option header bytes and byte counter ceiling (2 + 65535)
    localparam logic [15:0]      HDR_BYTES = 16'd4;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65537;

endpackage

`default_nettype wire

[hdl/edns_of_if.sv]
// Valid/ready channel interfaces of the EDNS option finder: byte input,
// result output and option code write channel. Depends on edns_of_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface edns_of_byte_if;
    import edns_of_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface edns_of_result_if;
    import edns_of_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic [15:0] option_offset;
    logic [15:0] option_size;

    modport source (output valid, output status, output option_offset,
                    output option_size, input ready);
    modport sink   (input valid, input status, input option_offset,
                    input option_size, output ready);
endinterface

interface edns_of_cfg_if;
    import edns_of_pkg::*;

    logic        valid;
    logic        ready;
    logic [15:0] wanted_code;

    modport source (output valid, output wanted_code, input ready);
    modport sink   (input valid, input wanted_code, output ready);
endinterface

`default_nettype wire

[hdl/edns_option_finder_top.sv]
// Top level of the EDNS option finder: walks OPT record rdata one byte per
// item and reports the first option matching the configured code.
// Depends on edns_of_pkg and the channel interfaces in edns_of_if.sv.
//
//  channel   dir   payload                                   item
//  in_ch     in    data_byte[7:0], last_byte                 one buffer byte
//  out_ch    out   status[1:0], option_offset, option_size   one result per buffer
//  cfg_ch    in    wanted_code[15:0]                         option code write
//
// One byte is taken per cycle; the parse state updates at the accepting edge.
// The result of a buffer is shown on out_ch the cycle after its last byte.
// in_ch stalls only while a result sits in the output register untaken.
// cfg_ch is always ready. Reset clears the parse state, the result valid
// and the option code (code 0).
`timescale 1ns / 1ps
`default_nettype none

module edns_option_finder_top
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    edns_of_byte_if.sink           in_ch,
    edns_of_result_if.source       out_ch,
    edns_of_cfg_if.sink            cfg_ch
);
    import edns_of_pkg::*;

    // State registers
    phase_t             phase_reg, phase_next, phase_upd;
    logic [CNT_W-1:0]   count_reg, count_next, count_upd;
    logic [15:0]        rdlen_reg, rdlen_next, rdlen_upd;
    logic [15:0]        consumed_reg, consumed_next, consumed_upd;
    logic [15:0]        code_reg, code_next, code_upd;
    logic [15:0]        olen_reg, olen_next, olen_upd;
    logic [15:0]        skip_reg, skip_next, skip_upd;
    logic               found_reg, found_next, found_upd;
    logic [15:0]        moff_reg, moff_next, moff_upd;
    logic [15:0]        msize_reg, msize_next, msize_upd;
    logic               overrun_reg, overrun_next, overrun_upd;
    logic               stopped_reg, stopped_next, stopped_upd;
    logic [15:0]        wanted_reg;

    // Result register
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [15:0]        out_off_reg, out_off_next;
    logic [15:0]        out_size_reg, out_size_next;

    logic               in_fire;
    logic               take;
    logic               finish;

    // Header arithmetic on the current byte
    logic [15:0]        consumed_inc;
    logic [15:0]        rdlen_full;
    logic [15:0]        olen_full;
    logic [15:0]        code_full;
    logic               room_lo;
    logic               room_next;
    logic               overrun_hit;
    logic               code_hit;
    logic               skip_done;
    logic               len_known;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign take         = in_fire && !stopped_reg;
    assign finish       = in_fire && in_ch.last_byte;

    assign consumed_inc = consumed_reg + 16'd1;
    assign rdlen_full   = {rdlen_reg[15:8], in_ch.data_byte};
    assign olen_full    = {olen_reg[15:8], in_ch.data_byte};
    assign code_full    = {code_reg[15:8], in_ch.data_byte};
    assign room_lo      = (rdlen_full - consumed_reg) >= HDR_BYTES;
    assign room_next    = (rdlen_reg - consumed_inc) >= HDR_BYTES;
    assign overrun_hit  = olen_full > (rdlen_reg - consumed_inc);
    assign code_hit     = code_reg == wanted_reg;
    assign skip_done    = skip_reg == 16'd1;

    // Phase next state
    always_comb
    begin
        phase_upd = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_LEN_HI:  phase_upd = PH_LEN_LO;
                PH_LEN_LO:  phase_upd = room_lo ? PH_CODE_HI : PH_LEN_LO;
                PH_CODE_HI: phase_upd = PH_CODE_LO;
                PH_CODE_LO: phase_upd = PH_OLEN_HI;
                PH_OLEN_HI: phase_upd = PH_OLEN_LO;
                PH_OLEN_LO:
                begin
                    if (overrun_hit || code_hit)
                        phase_upd = PH_OLEN_LO;
                    else if (olen_full == 16'd0)
                        phase_upd = room_next ? PH_CODE_HI : PH_OLEN_LO;
                    else
                        phase_upd = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (skip_done && room_next)
                        phase_upd = PH_CODE_HI;
                end
                default:    phase_upd = PH_LEN_HI;
            endcase
        end
        phase_next = finish ? PH_LEN_HI : phase_upd;
    end

    // Datapath updates for one byte
    always_comb
    begin
        count_upd    = (in_fire && count_reg < COUNT_MAX) ? count_reg + 17'd1 : count_reg;
        rdlen_upd    = rdlen_reg;
        consumed_upd = consumed_reg;
        code_upd     = code_reg;
        olen_upd     = olen_reg;
        skip_upd     = skip_reg;
        found_upd    = found_reg;
        moff_upd     = moff_reg;
        msize_upd    = msize_reg;
        overrun_upd  = overrun_reg;
        stopped_upd  = stopped_reg;
        if (take)
        begin
            case (phase_reg)
                PH_LEN_HI:
                    rdlen_upd = {in_ch.data_byte, 8'd0};
                PH_LEN_LO:
                begin
                    rdlen_upd = rdlen_full;
                    if (!room_lo)
                        stopped_upd = 1'b1;
                end
                PH_CODE_HI:
                begin
                    code_upd     = {in_ch.data_byte, 8'd0};
                    consumed_upd = consumed_inc;
                end
                PH_CODE_LO:
                begin
                    code_upd     = code_full;
                    consumed_upd = consumed_inc;
                end
                PH_OLEN_HI:
                begin
                    olen_upd     = {in_ch.data_byte, 8'd0};
                    consumed_upd = consumed_inc;
                end
                PH_OLEN_LO:
                begin
                    olen_upd     = olen_full;
                    consumed_upd = consumed_inc;
                    if (overrun_hit)
                    begin
                        overrun_upd = 1'b1;
                        stopped_upd = 1'b1;
                    end
                    else if (code_hit)
                    begin
                        found_upd   = 1'b1;
                        // header started four bytes back, rdata starts at offset 2
                        moff_upd    = consumed_inc - 16'd2;
                        msize_upd   = olen_full + HDR_BYTES;
                        stopped_upd = 1'b1;
                    end
                    else if (olen_full == 16'd0)
                    begin
                        if (!room_next)
                            stopped_upd = 1'b1;
                    end
                    else
                    begin
                        skip_upd = olen_full;
                    end
                end
                PH_SKIP:
                begin
                    consumed_upd = consumed_inc;
                    skip_upd     = skip_reg - 16'd1;
                    if (skip_done && !room_next)
                        stopped_upd = 1'b1;
                end
                default:
                    stopped_upd = stopped_reg;
            endcase
        end
    end

    // Result of the buffer and clearing of the parse state on the last byte
    assign len_known = (phase_upd != PH_LEN_HI && phase_upd != PH_LEN_LO) || stopped_upd;

    always_comb
    begin
        status_next   = STATUS_NOT_FOUND;
        out_off_next  = 16'd0;
        out_size_next = 16'd0;
        if (!len_known || count_upd < ({1'b0, rdlen_upd} + 17'd2) || overrun_upd)
        begin
            status_next = STATUS_INVALID;
        end
        else if (found_upd)
        begin
            status_next   = STATUS_FOUND;
            out_off_next  = moff_upd;
            out_size_next = msize_upd;
        end

        count_next    = finish ? '0 : count_upd;
        rdlen_next    = finish ? '0 : rdlen_upd;
        consumed_next = finish ? '0 : consumed_upd;
        code_next     = finish ? '0 : code_upd;
        olen_next     = finish ? '0 : olen_upd;
        skip_next     = finish ? '0 : skip_upd;
        found_next    = finish ? 1'b0 : found_upd;
        moff_next     = finish ? '0 : moff_upd;
        msize_next    = finish ? '0 : msize_upd;
        overrun_next  = finish ? 1'b0 : overrun_upd;
        stopped_next  = finish ? 1'b0 : stopped_upd;
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEN_HI;
            count_reg    <= '0;
            rdlen_reg    <= '0;
            consumed_reg <= '0;
            code_reg     <= '0;
            olen_reg     <= '0;
            skip_reg     <= '0;
            found_reg    <= 1'b0;
            moff_reg     <= '0;
            msize_reg    <= '0;
            overrun_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            rdlen_reg    <= rdlen_next;
            consumed_reg <= consumed_next;
            code_reg     <= code_next;
            olen_reg     <= olen_next;
            skip_reg     <= skip_next;
            found_reg    <= found_next;
            moff_reg     <= moff_next;
            msize_reg    <= msize_next;
            overrun_reg  <= overrun_next;
            stopped_reg  <= stopped_next;
        end
    end

    // Option code register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_reg <= '0;
        else if (cfg_ch.valid && cfg_ch.ready)
            wanted_reg <= cfg_ch.wanted_code;
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg   <= status_next;
            out_off_reg  <= out_off_next;
            out_size_reg <= out_size_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.option_offset = out_off_reg;
    assign out_ch.option_size   = out_size_reg;

endmodule

`default_nettype wire
